@@ hdl/gear_slot_detector_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the gear slot detector.
// Each macro builds one clocked concurrent assertion with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef GEAR_SLOT_DETECTOR_CORE_MACROS_SVH
`define GEAR_SLOT_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication.
`define GSD_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication.
`define GSD_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

@@ hdl/gsd_pkg.sv @@
// ----------------------------------------------------------------------------
// gsd_pkg
// Shared constants, types and helper functions of the gear slot detector.
// ----------------------------------------------------------------------------
package gsd_pkg;

  localparam int SLOTS      = 16;
  localparam int BUTTONS    = 32;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int COUNT_W    = $clog2(SLOTS + 1);
  localparam int POS_W      = 16;
  localparam int SIZE_W     = 12;
  localparam int GEAR_W     = 4;
  localparam int IDX_W      = 4;
  localparam int BTN_W      = 5;
  localparam int ACT_W      = 5;
  localparam int CNT_REG_W  = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int SQ_W       = 2 * POS_W;
  localparam int SCORE_W    = SQ_W + 1;

  localparam logic [GEAR_W-1:0] GEAR_REVERSE  = 4'd8;
  localparam logic [GEAR_W-1:0] GEAR_SEQ_DOWN = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 3'd0,
    CFG_FLIP_X = 3'd1,
    CFG_FLIP_Y = 3'd2,
    CFG_HYST   = 3'd3,
    CFG_COUNT  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACT_RD,
    ST_ACT_CHK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_CMP,
    ST_SCAN_END,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [POS_W-1:0] cen_y;
    logic signed [POS_W-1:0] cen_x;
    logic [SIZE_W-1:0]       half_h;
    logic [SIZE_W-1:0]       half_w;
    logic [GEAR_W-1:0]       gear;
  } slot_t;

  typedef struct packed {
    logic en;
    logic sel_y;
  } sq_ctrl_t;

  function automatic logic signed [POS_W-1:0] neg_sat(input logic signed [POS_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v == {1'b1, {(POS_W-1){1'b0}}}) begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = -v;
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                input logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    logic signed [POS_W:0] m;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    m = d[POS_W] ? -d : d;
    return m[POS_W-1:0];
  endfunction

  function automatic logic real_gear(input logic [GEAR_W-1:0] g);
    return g <= GEAR_REVERSE;
  endfunction

  function automatic logic press_gear(input logic [GEAR_W-1:0] g);
    return (g <= GEAR_SEQ_DOWN) && (int'(g) < BUTTONS);
  endfunction

endpackage

@@ hdl/gsd_req_if.sv @@
// ----------------------------------------------------------------------------
// gsd_req_if
// Request channel: position samples and slot table loads.
// ----------------------------------------------------------------------------
interface gsd_req_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic                               pos_valid;
  logic signed [gsd_pkg::POS_W-1:0]   x_pos;
  logic signed [gsd_pkg::POS_W-1:0]   y_pos;
  logic [gsd_pkg::IDX_W-1:0]          slot_index;
  logic signed [gsd_pkg::POS_W-1:0]   slot_center_x;
  logic signed [gsd_pkg::POS_W-1:0]   slot_center_y;
  logic [gsd_pkg::SIZE_W-1:0]         slot_half_width;
  logic [gsd_pkg::SIZE_W-1:0]         slot_half_height;
  logic [gsd_pkg::GEAR_W-1:0]         slot_gear;

  modport source (
    output valid, req_type, pos_valid, x_pos, y_pos, slot_index, slot_center_x,
           slot_center_y, slot_half_width, slot_half_height, slot_gear,
    input  ready
  );

  modport sink (
    input  valid, req_type, pos_valid, x_pos, y_pos, slot_index, slot_center_x,
           slot_center_y, slot_half_width, slot_half_height, slot_gear,
    output ready
  );
endinterface

@@ hdl/gsd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// gsd_rsp_if
// Response channel: button press and active slot of one sample.
// ----------------------------------------------------------------------------
interface gsd_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             press_valid;
  logic [gsd_pkg::BTN_W-1:0]        btn_code;
  logic signed [gsd_pkg::ACT_W-1:0] active_slot;

  modport source (
    output valid, press_valid, btn_code, active_slot,
    input  ready
  );

  modport sink (
    input  valid, press_valid, btn_code, active_slot,
    output ready
  );
endinterface

@@ hdl/gsd_slot_mem.sv @@
// ----------------------------------------------------------------------------
// gsd_slot_mem
// Slot table memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gsd_slot_mem (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [gsd_pkg::SLOT_W-1:0] waddr_i,
  input  gsd_pkg::slot_t             wdata_i,
  input  logic [gsd_pkg::SLOT_W-1:0] raddr_i,
  output gsd_pkg::slot_t             rdata_o
);
  import gsd_pkg::*;

  slot_t mem_q [SLOTS];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ hdl/gsd_sq_unit.sv @@
// ----------------------------------------------------------------------------
// gsd_sq_unit
// Shared registered squarer for the x and y distances of one slot.
// ----------------------------------------------------------------------------
module gsd_sq_unit (
  input  logic                      clk_i,
  input  gsd_pkg::sq_ctrl_t         ctrl_i,
  input  logic [gsd_pkg::POS_W-1:0] dx_i,
  input  logic [gsd_pkg::POS_W-1:0] dy_i,
  output logic [gsd_pkg::SQ_W-1:0]  sq_o
);
  import gsd_pkg::*;

  logic [POS_W-1:0] op;
  logic [SQ_W-1:0]  sq_q;

  assign op = ctrl_i.sel_y ? dy_i : dx_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      sq_q <= SQ_W'(op) * SQ_W'(op);
    end
  end

  assign sq_o = sq_q;
endmodule

@@ hdl/gear_slot_detector_core.sv @@
// ----------------------------------------------------------------------------
// gear_slot_detector_core: lever shifter gear slot classifier, top level.
// A load request gives no response; one request at a time.
// A sample responds directly when off, after a recheck of the active slot when it holds,
// else after a scan of the slots in use: table read, shared squarer.
// rst_ni (asynchronous, active low) clears configuration, active slot and handshakes.
// ----------------------------------------------------------------------------
module gear_slot_detector_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gsd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  gsd_req_if.sink                        req,
  gsd_rsp_if.source                      rsp
);
  import gsd_pkg::*;

  state_e state_q, state_d;

  logic                 en_q, inv_x_q, inv_y_q;
  logic [SIZE_W-1:0]    hyst_q;
  logic [CNT_REG_W-1:0] slot_count_q;

  logic                 act_valid_q;
  logic [SLOT_W-1:0]    act_idx_q;
  logic [COUNT_W-1:0]   idx_q;
  logic                 best_valid_q, has_gear_q, out_valid_q;
  logic [SCORE_W-1:0]   best_score_q;
  logic [SLOT_W-1:0]    best_idx_q;
  logic [GEAR_W-1:0]    best_gear_q, gear_q;
  logic signed [POS_W-1:0] x_q, y_q;
  logic [POS_W-1:0]     dx_q, dy_q;
  logic [SQ_W-1:0]      sqx_q;
  logic                 res_press_q, out_press_q;
  logic [BTN_W-1:0]     res_btn_q, out_btn_q;
  logic [ACT_W-1:0]     out_act_q;

  logic [COUNT_W-1:0]   count_c, idx_nxt;
  logic                 req_fire, is_load, trivial, act_ok, last_c, out_free;
  logic                 inside_c, better_c, start_scan, mem_we;
  logic [SIZE_W-1:0]    extra_c;
  logic [POS_W:0]       lim_x, lim_y;
  logic [POS_W-1:0]     dx_c, dy_c;
  logic [SCORE_W-1:0]   score_c;
  logic [SLOT_W-1:0]    raddr;
  slot_t                wdata, rd;
  sq_ctrl_t             sq_ctrl;
  logic [SQ_W-1:0]      sq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q         <= 1'b0;
      inv_x_q      <= 1'b0;
      inv_y_q      <= 1'b0;
      hyst_q       <= '0;
      slot_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE: en_q         <= cfg_data_i[0];
        CFG_FLIP_X: inv_x_q      <= cfg_data_i[0];
        CFG_FLIP_Y: inv_y_q      <= cfg_data_i[0];
        CFG_HYST:   hyst_q       <= cfg_data_i[SIZE_W-1:0];
        CFG_COUNT:  slot_count_q <= cfg_data_i[CNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign count_c  = (int'(slot_count_q) > SLOTS) ? COUNT_W'(SLOTS)
                                                 : COUNT_W'(slot_count_q);
  assign idx_nxt  = idx_q + COUNT_W'(1);
  assign last_c   = (idx_nxt == count_c);
  assign req_fire = req.valid && req.ready;
  assign is_load  = req.req_type;
  assign trivial  = !en_q || !req.pos_valid || (count_c == '0);
  assign act_ok   = act_valid_q && (COUNT_W'(act_idx_q) < count_c);
  assign out_free = !out_valid_q || rsp.ready;

  assign dx_c     = abs_diff(x_q, rd.cen_x);
  assign dy_c     = abs_diff(y_q, rd.cen_y);
  assign lim_x    = (POS_W+1)'(rd.half_w) + (POS_W+1)'(extra_c);
  assign lim_y    = (POS_W+1)'(rd.half_h) + (POS_W+1)'(extra_c);
  assign inside_c = ({1'b0, dx_c} <= lim_x) && ({1'b0, dy_c} <= lim_y);
  assign score_c  = {1'b0, sqx_q} + {1'b0, sq};
  assign better_c = !best_valid_q || (score_c < best_score_q);

  assign start_scan = ((state_q == ST_IDLE) && req_fire && !is_load && !trivial && !act_ok)
                   || ((state_q == ST_ACT_CHK) && !inside_c);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req.valid) begin
          if (is_load) begin
            state_d = ST_IDLE;
          end else if (trivial) begin
            state_d = ST_DONE;
          end else if (act_ok) begin
            state_d = ST_ACT_RD;
          end else begin
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_ACT_RD:   state_d = ST_ACT_CHK;
      ST_ACT_CHK:  state_d = inside_c ? ST_DONE : ST_SCAN_RD;
      ST_SCAN_RD:  state_d = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (inside_c) begin
          state_d = ST_SQ_X;
        end else begin
          state_d = last_c ? ST_SCAN_END : ST_SCAN_RD;
        end
      end
      ST_SQ_X:     state_d = ST_SQ_Y;
      ST_SQ_Y:     state_d = ST_SQ_CMP;
      ST_SQ_CMP:   state_d = last_c ? ST_SCAN_END : ST_SCAN_RD;
      ST_SCAN_END: state_d = ST_DONE;
      ST_DONE:     state_d = out_free ? ST_IDLE : ST_DONE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready     = (state_q == ST_IDLE);
    extra_c       = (state_q == ST_ACT_CHK) ? hyst_q : '0;
    raddr         = (state_q == ST_ACT_RD) ? act_idx_q : idx_q[SLOT_W-1:0];
    sq_ctrl.en    = (state_q == ST_SQ_X) || (state_q == ST_SQ_Y);
    sq_ctrl.sel_y = (state_q == ST_SQ_Y);
    mem_we        = (state_q == ST_IDLE) && req.valid && is_load
                 && (int'(req.slot_index) < SLOTS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_valid_q  <= 1'b0;
      act_idx_q    <= '0;
      idx_q        <= '0;
      best_valid_q <= 1'b0;
      has_gear_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if ((state_q == ST_IDLE) && req_fire && !is_load && (trivial || !act_ok)) begin
        act_valid_q <= 1'b0;
      end
      if ((state_q == ST_ACT_CHK) && !inside_c) begin
        act_valid_q <= 1'b0;
      end
      if (start_scan) begin
        idx_q        <= '0;
        best_valid_q <= 1'b0;
        has_gear_q   <= 1'b0;
      end
      if (state_q == ST_SCAN_CHK) begin
        if (real_gear(rd.gear)) begin
          has_gear_q <= 1'b1;
        end
        if (!inside_c) begin
          idx_q <= idx_nxt;
        end
      end
      if (state_q == ST_SQ_CMP) begin
        idx_q <= idx_nxt;
        if (better_c) begin
          best_valid_q <= 1'b1;
        end
      end
      if (state_q == ST_SCAN_END) begin
        act_valid_q <= best_valid_q;
        act_idx_q   <= best_idx_q;
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && req_fire) begin
      x_q <= inv_x_q ? neg_sat(req.x_pos) : req.x_pos;
      y_q <= inv_y_q ? neg_sat(req.y_pos) : req.y_pos;
      if (!is_load && trivial) begin
        res_press_q <= 1'b0;
        res_btn_q   <= '0;
      end
    end
    if ((state_q == ST_ACT_CHK) && inside_c) begin
      res_press_q <= press_gear(rd.gear);
      res_btn_q   <= press_gear(rd.gear) ? BTN_W'(rd.gear) : '0;
    end
    if ((state_q == ST_SCAN_CHK) && inside_c) begin
      dx_q   <= dx_c;
      dy_q   <= dy_c;
      gear_q <= rd.gear;
    end
    if (state_q == ST_SQ_Y) begin
      sqx_q <= sq;
    end
    if ((state_q == ST_SQ_CMP) && better_c) begin
      best_score_q <= score_c;
      best_idx_q   <= idx_q[SLOT_W-1:0];
      best_gear_q  <= gear_q;
    end
    if (state_q == ST_SCAN_END) begin
      if (best_valid_q) begin
        res_press_q <= press_gear(best_gear_q);
        res_btn_q   <= press_gear(best_gear_q) ? BTN_W'(best_gear_q) : '0;
      end else begin
        res_press_q <= has_gear_q && (BUTTONS > 0);
        res_btn_q   <= '0;
      end
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_press_q <= res_press_q;
      out_btn_q   <= res_btn_q;
      out_act_q   <= act_valid_q ? ACT_W'(act_idx_q) : '1;
    end
  end

  assign wdata.cen_y  = req.slot_center_y;
  assign wdata.cen_x  = req.slot_center_x;
  assign wdata.half_h = req.slot_half_height;
  assign wdata.half_w = req.slot_half_width;
  assign wdata.gear   = req.slot_gear;

  gsd_slot_mem u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (req.slot_index[SLOT_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  gsd_sq_unit u_sq_unit (
    .clk_i  (clk_i),
    .ctrl_i (sq_ctrl),
    .dx_i   (dx_q),
    .dy_i   (dy_q),
    .sq_o   (sq)
  );

  assign rsp.valid       = out_valid_q;
  assign rsp.press_valid = out_press_q;
  assign rsp.btn_code    = out_btn_q;
  assign rsp.active_slot = out_act_q;
endmodule

@@ hdl/gsd_checker.sv @@
// ----------------------------------------------------------------------------
// gsd_checker
// Port-level checks of the gear slot detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "gear_slot_detector_core_macros.svh"

module gsd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           req_type_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic                           rsp_press_valid_i,
  input logic [gsd_pkg::BTN_W-1:0]      rsp_btn_code_i,
  input logic [gsd_pkg::ACT_W-1:0]      rsp_active_slot_i
);
  import gsd_pkg::*;

  // A stalled response keeps its contents.
  `GSD_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_press_valid_i) && $stable(rsp_btn_code_i) && $stable(rsp_active_slot_i))

  // A sample keeps the block busy in the following cycle.
  `GSD_ASSERT_NXT(a_sample_busy, clk_i, rst_ni, req_valid_i && req_ready_i && !req_type_i, !req_ready_i)

  // A table load leaves the block ready again in the next cycle.
  `GSD_ASSERT_NXT(a_load_done, clk_i, rst_ni, req_valid_i && req_ready_i && req_type_i, req_ready_i)

  // Without a press the button code reads zero.
  `GSD_ASSERT_IMP(a_no_press_btn, clk_i, rst_ni, rsp_valid_i && !rsp_press_valid_i, rsp_btn_code_i == '0)
endmodule

bind gear_slot_detector_core gsd_checker u_gsd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req.valid),
  .req_ready_i       (req.ready),
  .req_type_i        (req.req_type),
  .rsp_valid_i       (rsp.valid),
  .rsp_ready_i       (rsp.ready),
  .rsp_press_valid_i (rsp.press_valid),
  .rsp_btn_code_i    (rsp.btn_code),
  .rsp_active_slot_i (rsp.active_slot)
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: gear slot detector core
// Sends slot table loads and lever position samples over the request channel,
// with random gaps and response back-pressure. Settings change only between
// phases, while the block is idle. A scoreboard object predicts the press and
// the active slot of every sample and checks each response in order.
// ----------------------------------------------------------------------------
module testbench;
  import gsd_pkg::*;

  localparam int LIMIT_NS      = 3_000_000;
  localparam int SETTLE_CYCLES = 100;
  localparam int ITEM_TARGET   = 950;
  localparam int GEAR_NEUTRAL  = 0;
  localparam int GEAR_MAX      = 15;
  localparam int POS_MIN       = -32768;
  localparam int POS_MAX       = 32767;

  typedef struct {
    logic                    req_type;
    logic                    pos_valid;
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic [IDX_W-1:0]        slot_index;
    logic signed [POS_W-1:0] slot_center_x;
    logic signed [POS_W-1:0] slot_center_y;
    logic [SIZE_W-1:0]       slot_half_width;
    logic [SIZE_W-1:0]       slot_half_height;
    logic [GEAR_W-1:0]       slot_gear;
  } lever_req_t;

  typedef struct {
    logic             press_valid;
    logic [BTN_W-1:0] btn_code;
    logic [ACT_W-1:0] active_slot;
  } press_t;

  class press_scoreboard;
    bit     enable;
    bit     flip_x;
    bit     flip_y;
    int     hysteresis;
    int     slot_count;
    int     cen_x[SLOTS];
    int     cen_y[SLOTS];
    int     half_w[SLOTS];
    int     half_h[SLOTS];
    int     gear[SLOTS];
    int     active_idx;
    press_t press_q[$];
    int     errors;

    function new();
      active_idx = -1;
      errors     = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ENABLE: enable = data[0];
        CFG_FLIP_X: flip_x = data[0];
        CFG_FLIP_Y: flip_y = data[0];
        CFG_HYST:   hysteresis = int'(data[SIZE_W-1:0]);
        CFG_COUNT:  slot_count = int'(data[CNT_REG_W-1:0]);
        default: ;
      endcase
    endfunction

    function int flip_axis(int v);
      return (v == POS_MIN) ? POS_MAX : -v;
    endfunction

    function int gap_of(int a, int b);
      return (a >= b) ? a - b : b - a;
    endfunction

    function bit covers(int i, int x, int y, int extra);
      return gap_of(x, cen_x[i]) <= half_w[i] + extra &&
             gap_of(y, cen_y[i]) <= half_h[i] + extra;
    endfunction

    function press_t classify_sample(lever_req_t it);
      press_t   r;
      int       used;
      int       x;
      int       y;
      int       best_i;
      int       g;
      longint   best;
      longint   score;
      longint   dx;
      longint   dy;
      bit       has_gear;
      r.press_valid = 1'b0;
      r.btn_code    = '0;
      has_gear      = 1'b0;
      used = (slot_count > SLOTS) ? SLOTS : slot_count;
      if (!enable || !it.pos_valid || used == 0) begin
        active_idx = -1;
      end else begin
        x = it.x_pos;
        y = it.y_pos;
        if (flip_x) x = flip_axis(x);
        if (flip_y) y = flip_axis(y);
        if (active_idx >= used) active_idx = -1;
        if (active_idx >= 0 && !covers(active_idx, x, y, hysteresis)) active_idx = -1;
        if (active_idx < 0) begin
          best   = 0;
          best_i = -1;
          for (int i = 0; i < used; i++) begin
            if (gear[i] <= int'(GEAR_REVERSE)) has_gear = 1'b1;
            if (covers(i, x, y, 0)) begin
              dx    = gap_of(x, cen_x[i]);
              dy    = gap_of(y, cen_y[i]);
              score = dx * dx + dy * dy;
              if (best_i < 0 || score < best) begin
                best   = score;
                best_i = i;
              end
            end
          end
          active_idx = best_i;
        end
        if (active_idx >= 0) begin
          g = gear[active_idx];
          if (g <= int'(GEAR_SEQ_DOWN) && g < BUTTONS) begin
            r.press_valid = 1'b1;
            r.btn_code    = BTN_W'(g);
          end
        end else if (has_gear) begin
          r.press_valid = 1'b1;
          r.btn_code    = BTN_W'(GEAR_NEUTRAL);
        end
      end
      r.active_slot = active_idx[ACT_W-1:0];
      return r;
    endfunction

    function void take_request(lever_req_t it);
      int idx;
      if (it.req_type) begin
        idx         = int'(it.slot_index);
        cen_x[idx]  = it.slot_center_x;
        cen_y[idx]  = it.slot_center_y;
        half_w[idx] = int'(it.slot_half_width);
        half_h[idx] = int'(it.slot_half_height);
        gear[idx]   = int'(it.slot_gear);
      end else begin
        press_q.push_back(classify_sample(it));
      end
    endfunction

    function void match_press(press_t seen);
      press_t want;
      if (press_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected response: valid %0b button %0d slot %0d",
                   seen.press_valid, seen.btn_code, $signed(seen.active_slot));
      end else begin
        want = press_q.pop_front();
        if (seen.press_valid !== want.press_valid || seen.btn_code !== want.btn_code ||
            seen.active_slot !== want.active_slot) begin
          errors++;
          if (errors <= 10)
            $display("press mismatch: expected valid %0b button %0d slot %0d, got valid %0b button %0d slot %0d",
                     want.press_valid, want.btn_code, $signed(want.active_slot),
                     seen.press_valid, seen.btn_code, $signed(seen.active_slot));
        end
      end
    endfunction

    function void close_out();
      if (press_q.size() != 0) begin
        errors += press_q.size();
        $display("responses missing at end: %0d", press_q.size());
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  gsd_req_if req_ch ();
  gsd_rsp_if rsp_ch ();

  gear_slot_detector_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  press_scoreboard sb = new();

  int     items_sent = 0;
  int     hold_asked = 0;
  int     hold_given = 0;
  int     rsp_stall  = 0;
  int     calm_left  = 0;
  int     rsp_pick;
  int     last_tx    = 0;
  int     last_ty    = 0;
  press_t rsp_seen;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("testbench: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      rsp_seen.press_valid = rsp_ch.press_valid;
      rsp_seen.btn_code    = rsp_ch.btn_code;
      rsp_seen.active_slot = rsp_ch.active_slot;
      sb.match_press(rsp_seen);
    end
    if (hold_asked != hold_given) begin
      hold_given = hold_asked;
      rsp_stall  = 400;
    end
    if (rsp_stall > 0) begin
      rsp_stall--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (calm_left > 0) begin
        calm_left--;
      end else begin
        rsp_pick = $urandom_range(0, 999);
        if (rsp_pick < 5) calm_left = $urandom_range(50, 300);
        else if (rsp_pick < 150) rsp_stall = $urandom_range(1, 3);
        else if (rsp_pick < 170) rsp_stall = $urandom_range(20, 50);
      end
    end
  end

  function automatic int clamp16(int v);
    return (v < POS_MIN) ? POS_MIN : (v > POS_MAX) ? POS_MAX : v;
  endfunction

  function automatic int any_pos();
    return int'($urandom_range(0, 65535)) + POS_MIN;
  endfunction

  function automatic int next_gap(bit gapless);
    int pick;
    pick = $urandom_range(0, 99);
    if (gapless || pick < 60) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic lever_req_t noise_req();
    lever_req_t it;
    it.req_type         = 1'b0;
    it.pos_valid        = 1'($urandom);
    it.x_pos            = POS_W'($urandom);
    it.y_pos            = POS_W'($urandom);
    it.slot_index       = IDX_W'($urandom);
    it.slot_center_x    = POS_W'($urandom);
    it.slot_center_y    = POS_W'($urandom);
    it.slot_half_width  = SIZE_W'($urandom);
    it.slot_half_height = SIZE_W'($urandom);
    it.slot_gear        = GEAR_W'($urandom);
    return it;
  endfunction

  function automatic lever_req_t sample_req(logic pv, int x, int y);
    lever_req_t it;
    it           = noise_req();
    it.pos_valid = pv;
    it.x_pos     = POS_W'(x);
    it.y_pos     = POS_W'(y);
    return it;
  endfunction

  function automatic lever_req_t load_req(int idx, int cx, int cy, int hw, int hh, int g);
    lever_req_t it;
    it                  = noise_req();
    it.req_type         = 1'b1;
    it.slot_index       = IDX_W'(idx);
    it.slot_center_x    = POS_W'(cx);
    it.slot_center_y    = POS_W'(cy);
    it.slot_half_width  = SIZE_W'(hw);
    it.slot_half_height = SIZE_W'(hh);
    it.slot_gear        = GEAR_W'(g);
    return it;
  endfunction

  function automatic int pick_half();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return 0;
    if (pick < 20) return (1 << SIZE_W) - 1;
    return $urandom_range(50, 1500);
  endfunction

  function automatic lever_req_t random_slot_req(int idx, int bx, int by, bit no_real);
    int cx;
    int cy;
    int g;
    if ($urandom_range(0, 99) < 5) begin
      cx = any_pos();
      cy = any_pos();
    end else begin
      cx = clamp16(bx + int'($urandom_range(0, 4000)) - 2000);
      cy = clamp16(by + int'($urandom_range(0, 4000)) - 2000);
    end
    if (no_real) g = $urandom_range(int'(GEAR_REVERSE) + 1, GEAR_MAX);
    else if ($urandom_range(0, 99) < 80) g = $urandom_range(GEAR_NEUTRAL, int'(GEAR_SEQ_DOWN));
    else g = $urandom_range(int'(GEAR_SEQ_DOWN) + 1, GEAR_MAX);
    return load_req(idx, cx, cy, pick_half(), pick_half(), g);
  endfunction

  task automatic push_request(input lever_req_t it, input int gap);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid            <= 1'b1;
    req_ch.req_type         <= it.req_type;
    req_ch.pos_valid        <= it.pos_valid;
    req_ch.x_pos            <= it.x_pos;
    req_ch.y_pos            <= it.y_pos;
    req_ch.slot_index       <= it.slot_index;
    req_ch.slot_center_x    <= it.slot_center_x;
    req_ch.slot_center_y    <= it.slot_center_y;
    req_ch.slot_half_width  <= it.slot_half_width;
    req_ch.slot_half_height <= it.slot_half_height;
    req_ch.slot_gear        <= it.slot_gear;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sb.take_request(it);
    items_sent++;
  endtask

  task automatic go_idle();
    req_ch.valid <= 1'b0;
    while (sb.press_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk_i);
    sb.set_register(idx, CFG_DATA_W'(value));
  endtask

  task automatic apply_settings(input bit en, input bit ix, input bit iy, input int hyst,
                                input int cnt);
    go_idle();
    write_reg(CFG_ENABLE, en);
    write_reg(CFG_FLIP_X, ix);
    write_reg(CFG_FLIP_Y, iy);
    write_reg(CFG_HYST, hyst);
    write_reg(CFG_COUNT, cnt);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    lever_req_t it;
    lever_req_t prev_slot;
    int         phase;
    int         en;
    int         ix;
    int         iy;
    int         hyst;
    int         cnt;
    int         in_use;
    int         nload;
    int         bx;
    int         by;
    int         pick;
    int         k;
    int         span_x;
    int         span_y;
    int         tx;
    int         ty;
    bit         no_real;
    bit         gapless;

    rst_ni                  <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_idx                 <= CFG_ENABLE;
    cfg_data                <= '0;
    req_ch.valid            <= 1'b0;
    req_ch.req_type         <= 1'b0;
    req_ch.pos_valid        <= 1'b0;
    req_ch.x_pos            <= '0;
    req_ch.y_pos            <= '0;
    req_ch.slot_index       <= '0;
    req_ch.slot_center_x    <= '0;
    req_ch.slot_center_y    <= '0;
    req_ch.slot_half_width  <= '0;
    req_ch.slot_half_height <= '0;
    req_ch.slot_gear        <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset settings, ties, hysteresis, stale index, saturation.
    push_request(sample_req(1'b1, 0, 0), next_gap(1'b0));
    push_request(load_req(0, 0, 0, 100, 100, GEAR_NEUTRAL), next_gap(1'b0));
    push_request(load_req(1, 1000, 0, 200, 200, 1), next_gap(1'b0));
    push_request(load_req(2, 1000, 0, 200, 200, int'(GEAR_SEQ_DOWN)), next_gap(1'b0));
    push_request(load_req(3, POS_MIN, POS_MAX, 4095, 4095, GEAR_MAX), next_gap(1'b0));
    apply_settings(1'b1, 1'b0, 1'b0, 0, 4);
    push_request(sample_req(1'b1, 1000, 0), next_gap(1'b0));
    push_request(sample_req(1'b1, 1150, -190), next_gap(1'b0));
    push_request(sample_req(1'b1, 5000, 5000), next_gap(1'b0));
    push_request(sample_req(1'b1, POS_MIN, POS_MAX), next_gap(1'b0));
    push_request(sample_req(1'b0, POS_MIN, POS_MAX), next_gap(1'b0));
    push_request(sample_req(1'b1, POS_MIN, POS_MAX), next_gap(1'b0));
    push_request(sample_req(1'b1, 0, 0), next_gap(1'b0));
    push_request(sample_req(1'b1, POS_MIN, POS_MAX), next_gap(1'b0));
    apply_settings(1'b1, 1'b0, 1'b0, 0, 2);
    push_request(sample_req(1'b1, POS_MIN, POS_MAX), next_gap(1'b0));
    apply_settings(1'b1, 1'b1, 1'b1, 4095, 4);
    push_request(sample_req(1'b1, POS_MAX, -POS_MAX), next_gap(1'b0));
    push_request(sample_req(1'b1, POS_MIN, POS_MIN), next_gap(1'b0));
    push_request(sample_req(1'b1, -1000, 0), next_gap(1'b0));
    push_request(sample_req(1'b1, -3000, 0), next_gap(1'b0));
    apply_settings(1'b0, 1'b0, 1'b0, 0, 4);
    push_request(sample_req(1'b1, 1000, 0), next_gap(1'b0));
    apply_settings(1'b1, 1'b0, 1'b0, 0, 0);
    push_request(sample_req(1'b1, 1000, 0), next_gap(1'b0));

    // Random phases: a fresh slot layout, then samples aimed mostly at it.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: begin en = 1; ix = 0; iy = 0; hyst = 0; cnt = SLOTS; end
        1: begin en = 1; ix = 1; iy = 1; hyst = 4095; cnt = 31; end
        2: begin en = 1; ix = 0; iy = 1; hyst = $urandom_range(0, 200); cnt = 1; end
        3: begin en = 1; ix = 1; iy = 0; hyst = 50; cnt = 0; end
        4: begin
          en = 0; ix = $urandom_range(0, 1); iy = $urandom_range(0, 1);
          hyst = $urandom_range(0, 4095); cnt = 8;
        end
        default: begin
          en = ($urandom_range(0, 9) != 0);
          ix = $urandom_range(0, 1);
          iy = $urandom_range(0, 1);
          pick = $urandom_range(0, 3);
          hyst = (pick == 0) ? 0 : (pick == 1) ? 4095 :
                 (pick == 2) ? $urandom_range(0, 300) : $urandom_range(0, 4095);
          pick = $urandom_range(0, 19);
          cnt = (pick == 0) ? 0 : (pick < 3) ? $urandom_range(SLOTS + 1, 31) :
                $urandom_range(1, SLOTS);
        end
      endcase
      apply_settings(en[0], ix[0], iy[0], hyst, cnt);
      in_use  = (cnt > SLOTS) ? SLOTS : cnt;
      nload   = (in_use < 4) ? 4 : in_use;
      no_real = (phase == 2) || ($urandom_range(0, 9) == 0);
      gapless = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) == 0) begin
        bx = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
        by = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
      end else begin
        bx = int'($urandom_range(0, 40000)) - 20000;
        by = int'($urandom_range(0, 40000)) - 20000;
      end
      for (int i = 0; i < nload; i++) begin
        if (i > 0 && $urandom_range(0, 99) < 15) begin
          it            = prev_slot;
          it.slot_index = IDX_W'(i);
          it.slot_gear  = no_real ? GEAR_W'($urandom_range(int'(GEAR_REVERSE) + 1, GEAR_MAX)) :
                                    GEAR_W'($urandom);
        end else begin
          it = random_slot_req(i, bx, by, no_real);
        end
        prev_slot = it;
        push_request(it, next_gap(gapless));
      end
      for (k = 0; k < 60; k++) begin
        if (phase == 1 && k == 10) hold_asked++;
        if (phase == 3 && k == 30) go_idle();
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          push_request(random_slot_req($urandom_range(0, SLOTS - 1), bx, by, no_real),
                       next_gap(gapless));
        end else if (pick < 9) begin
          push_request(sample_req(1'b0, any_pos(), any_pos()), next_gap(gapless));
        end else if (pick < 14) begin
          tx = $urandom_range(0, 1) ? POS_MIN : ($urandom_range(0, 1) ? POS_MAX : 0);
          ty = $urandom_range(0, 1) ? POS_MIN : ($urandom_range(0, 1) ? POS_MAX : -1);
          push_request(sample_req(1'b1, tx, ty), next_gap(gapless));
        end else if (pick < 24) begin
          push_request(sample_req(1'b1, any_pos(), any_pos()), next_gap(gapless));
        end else begin
          if (pick < 40) begin
            tx = clamp16(last_tx + int'($urandom_range(0, 600)) - 300);
            ty = clamp16(last_ty + int'($urandom_range(0, 600)) - 300);
          end else begin
            pick   = $urandom_range(0, nload - 1);
            span_x = sb.half_w[pick] + sb.hysteresis + 20;
            span_y = sb.half_h[pick] + sb.hysteresis + 20;
            tx = clamp16(sb.cen_x[pick] + int'($urandom_range(0, 2 * span_x)) - span_x);
            ty = clamp16(sb.cen_y[pick] + int'($urandom_range(0, 2 * span_y)) - span_y);
          end
          last_tx = tx;
          last_ty = ty;
          push_request(sample_req(1'b1, sb.flip_x ? clamp16(-tx) : tx,
                                  sb.flip_y ? clamp16(-ty) : ty), next_gap(gapless));
        end
      end
      phase++;
    end

    go_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/gsd_pkg.sv
hdl/gsd_req_if.sv
hdl/gsd_rsp_if.sv
hdl/gsd_slot_mem.sv
hdl/gsd_sq_unit.sv
hdl/gear_slot_detector_core.sv
hdl/gsd_checker.sv
dv/testbench.sv
